### rtl/core/szp_pkg.sv
// Shared types, codes and tables for the stepper zone positioner.
`timescale 1ns / 1ps
`default_nettype none

package szp_pkg;

  // Widths of the position, phase and zone quantities.
  localparam int unsigned PosWidth   = 7;
  localparam int unsigned PhaseWidth = 3;
  localparam int unsigned ZoneWidth  = 3;

  // Reset values of the configuration registers.
  localparam logic [PosWidth-1:0] FirstZonePositionReset = 7'd66;
  localparam logic [PosWidth-1:0] ZoneSpacingReset       = 7'd12;
  localparam logic [PosWidth-1:0] TravelLimitReset       = 7'd71;

  // Input action codes.
  typedef enum logic {
    ACT_TICK    = 1'b0,
    ACT_MESSAGE = 1'b1
  } action_t;

  // Travel direction codes.
  typedef enum logic {
    DIR_UP   = 1'b0,
    DIR_DOWN = 1'b1
  } heading_t;

  // Configuration register indexes (word address on the APB port).
  typedef enum logic [1:0] {
    REG_FIRST_ZONE_POSITION = 2'd0,
    REG_ZONE_SPACING        = 2'd1,
    REG_TRAVEL_LIMIT        = 2'd2
  } reg_index_t;

  // Zone codes with special meaning.
  localparam logic [ZoneWidth-1:0] ZoneNone   = 3'd0;
  localparam logic [ZoneWidth-1:0] ZoneIgnore = 3'd7;

  // Result of decoding one zone message.
  typedef struct packed {
    logic                hit;
    logic [PosWidth-1:0] target;
  } zone_target_t;

  // Half-step coil table, bit 3 drives coil one and bit 0 drives coil four.
  function automatic logic [3:0] coil_lookup(input logic [PhaseWidth-1:0] phase);
    logic [3:0] coils;
    case (phase)
      3'd0:    coils = 4'hA;
      3'd1:    coils = 4'h8;
      3'd2:    coils = 4'h9;
      3'd3:    coils = 4'h1;
      3'd4:    coils = 4'h5;
      3'd5:    coils = 4'h4;
      3'd6:    coils = 4'h6;
      default: coils = 4'h2;
    endcase
    return coils;
  endfunction

endpackage

`default_nettype wire

### rtl/core/szp_zone_target.sv
// Zone message decoder: picks the first nonzero zone field and works out its target.
`timescale 1ns / 1ps
`default_nettype none

module szp_zone_target (
  input  wire logic [7:0]                  zone_byte_hi,
  input  wire logic [7:0]                  zone_byte_lo,
  input  wire logic [szp_pkg::PosWidth-1:0] first_zone_position,
  input  wire logic [szp_pkg::PosWidth-1:0] zone_spacing,
  input  wire logic [szp_pkg::PosWidth-1:0] travel_limit,
  output szp_pkg::zone_target_t             zone_target
);

  logic [szp_pkg::ZoneWidth-1:0] zone;
  logic [szp_pkg::ZoneWidth-1:0] zone_offset;
  logic [9:0]                    offset_steps;
  logic [10:0]                   raw_target;

  // Priority pick: high byte upper field first, low byte lower field last.
  always_comb begin
    if (zone_byte_hi[5:3] != szp_pkg::ZoneNone) begin
      zone = zone_byte_hi[5:3];
    end else if (zone_byte_hi[2:0] != szp_pkg::ZoneNone) begin
      zone = zone_byte_hi[2:0];
    end else if (zone_byte_lo[5:3] != szp_pkg::ZoneNone) begin
      zone = zone_byte_lo[5:3];
    end else begin
      zone = zone_byte_lo[2:0];
    end
  end

  // Target is the zone one position less the spacing per zone step.
  assign zone_offset  = zone - 3'd1;
  assign offset_steps = 10'(zone_spacing * zone_offset);
  assign raw_target   = {4'b0, first_zone_position} - {1'b0, offset_steps};

  // Clamp into the travel range and flag zones that carry no target.
  always_comb begin
    zone_target.hit = (zone != szp_pkg::ZoneNone) && (zone != szp_pkg::ZoneIgnore);
    if (raw_target[10]) begin
      zone_target.target = '0;
    end else if (raw_target[6:0] > travel_limit) begin
      zone_target.target = travel_limit;
    end else begin
      zone_target.target = raw_target[6:0];
    end
  end

endmodule

`default_nettype wire

### rtl/core/stepper_zone_positioner.sv
// Top level of the stepper zone positioner: input stage, step logic, result stage, APB registers.
`timescale 1ns / 1ps
`default_nettype none

// A transaction on the input channel is either a step tick or a zone message. Each
// transaction gives exactly one result transaction, which passes through the input
// register and then the result register. The block takes one transaction every
// cycle while the output side accepts results: the only loop is the position, phase
// and heading update, a single increment and compare done between the input
// register and the result register. A message sets the target from the first
// nonzero zone field; a tick moves the motor one half step toward the target and
// reports the coil pattern of the phase it leaves. Registers at byte addresses 0,
// 4 and 8 hold the zone one position, the zone spacing and the travel limit; write
// them only while no transaction is in flight.
module stepper_zone_positioner (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [7:0]  zone_byte_hi,
  input  wire logic [7:0]  zone_byte_lo,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       coil_pattern,
  output logic             stepped,
  output logic [6:0]       position,
  output logic             moving,
  output logic             heading,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned PW = szp_pkg::PosWidth;

  // Configuration registers
  logic [PW-1:0] first_zone_position;
  logic [PW-1:0] zone_spacing;
  logic [PW-1:0] travel_limit;
  logic          cfg_write;

  // Input stage
  logic          s1_valid;
  logic          s1_action;
  logic [7:0]    s1_hi;
  logic [7:0]    s1_lo;
  logic          s1_fire;

  // Motor state
  logic [PW-1:0]                     step_position;
  logic [PW-1:0]                     step_position_next;
  logic [szp_pkg::PhaseWidth-1:0]    phase_index;
  logic [szp_pkg::PhaseWidth-1:0]    phase_index_next;
  logic                              travel_direction;
  logic                              travel_direction_next;
  logic [PW-1:0]                     target_position;
  logic [PW-1:0]                     target_position_next;
  logic [3:0]                        coil_next;
  logic                              stepped_next;

  // Step helpers
  logic                 step_dir;
  logic [PW-1:0]        moved_position;
  szp_pkg::zone_target_t zone_target;

  // APB write decode; the port never stalls.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_zone_position <= szp_pkg::FirstZonePositionReset;
      zone_spacing        <= szp_pkg::ZoneSpacingReset;
      travel_limit        <= szp_pkg::TravelLimitReset;
    end else if (cfg_write) begin
      case (szp_pkg::reg_index_t'(paddr[3:2]))
        szp_pkg::REG_FIRST_ZONE_POSITION: first_zone_position <= pwdata[PW-1:0];
        szp_pkg::REG_ZONE_SPACING:        zone_spacing        <= pwdata[PW-1:0];
        szp_pkg::REG_TRAVEL_LIMIT:        travel_limit        <= pwdata[PW-1:0];
        default: ;
      endcase
    end
  end

  // APB read mux.
  always_comb begin
    case (szp_pkg::reg_index_t'(paddr[3:2]))
      szp_pkg::REG_FIRST_ZONE_POSITION: prdata = {25'b0, first_zone_position};
      szp_pkg::REG_ZONE_SPACING:        prdata = {25'b0, zone_spacing};
      szp_pkg::REG_TRAVEL_LIMIT:        prdata = {25'b0, travel_limit};
      default:                          prdata = '0;
    endcase
  end

  // The input stage moves on whenever the result register is free or being emptied.
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_hi     <= zone_byte_hi;
      s1_lo     <= zone_byte_lo;
    end
  end

  // Zone message decode.
  szp_zone_target u_zone_target (
    .zone_byte_hi        (s1_hi),
    .zone_byte_lo        (s1_lo),
    .first_zone_position (first_zone_position),
    .zone_spacing        (zone_spacing),
    .travel_limit        (travel_limit),
    .zone_target         (zone_target)
  );

  // One half step toward the target.
  assign step_dir       = (target_position < step_position) ? szp_pkg::DIR_DOWN
                                                             : szp_pkg::DIR_UP;
  assign moved_position = (step_dir == szp_pkg::DIR_DOWN) ? step_position - 7'd1
                                                          : step_position + 7'd1;

  // Next state and result for the transaction in the input stage.
  always_comb begin
    step_position_next    = step_position;
    phase_index_next      = phase_index;
    travel_direction_next = travel_direction;
    target_position_next  = target_position;
    coil_next             = '0;
    stepped_next          = 1'b0;
    if (s1_action == szp_pkg::ACT_MESSAGE) begin
      if (zone_target.hit) begin
        target_position_next = zone_target.target;
      end
    end else if (step_position != target_position) begin
      coil_next          = szp_pkg::coil_lookup(phase_index);
      stepped_next       = 1'b1;
      step_position_next = moved_position;
      phase_index_next   = (step_dir == szp_pkg::DIR_DOWN) ? phase_index - 3'd1
                                                           : phase_index + 3'd1;
      // Turn round at the travel ends.
      if (moved_position == travel_limit) begin
        travel_direction_next = szp_pkg::DIR_DOWN;
      end else if (moved_position == '0) begin
        travel_direction_next = szp_pkg::DIR_UP;
      end else begin
        travel_direction_next = step_dir;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_position    <= '0;
      phase_index      <= '0;
      travel_direction <= szp_pkg::DIR_UP;
      target_position  <= '0;
    end else if (s1_fire) begin
      step_position    <= step_position_next;
      phase_index      <= phase_index_next;
      travel_direction <= travel_direction_next;
      target_position  <= target_position_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      coil_pattern <= coil_next;
      stepped      <= stepped_next;
      position     <= step_position_next;
      moving       <= (step_position_next != target_position_next);
      heading      <= travel_direction_next;
    end
  end

  // The phase always tracks the low bits of the position, since both start at zero
  // and move together.
  assert property (@(posedge clk) disable iff (rst)
    phase_index == step_position[szp_pkg::PhaseWidth-1:0])
    else $error("phase index out of step with position");

  // A message never moves the motor.
  assert property (@(posedge clk) disable iff (rst)
    s1_fire && (s1_action == szp_pkg::ACT_MESSAGE) |=> $stable(step_position))
    else $error("position changed on a zone message");

  // A stepped result always drives some coil, and an idle one drives none.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (stepped == (coil_pattern != 4'h0)))
    else $error("coil pattern does not match step flag");

  // An empty result register never blocks the input side.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the stepper zone positioner: random traffic, APB setup, predictor.
`timescale 1ns / 1ps

module tb_top;

  // The cycle limit is many times the length of the slowest correct run.
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned PhaseItems = 110;

  // One result transaction as the block reports it.
  typedef struct packed {
    logic [3:0]        coils;
    logic              stepped;
    logic [6:0]        pos;
    logic              moving;
    szp_pkg::heading_t dir;
  } move_t;

  // Tracks motor position, phase, heading and target, and holds the moves still to come.
  class motion_tracker;
    logic [6:0]        first_pos;
    logic [6:0]        spacing;
    logic [6:0]        limit;
    logic [6:0]        cur_pos;
    logic [6:0]        goal;
    logic [2:0]        phase;
    szp_pkg::heading_t dir;
    logic [3:0]        coil_seq [8];
    move_t             pending_moves [$];
    int unsigned       mismatches;

    function new();
      coil_seq = '{4'hA, 4'h8, 4'h9, 4'h1, 4'h5, 4'h4, 4'h6, 4'h2};
      first_pos = szp_pkg::FirstZonePositionReset;
      spacing = szp_pkg::ZoneSpacingReset;
      limit = szp_pkg::TravelLimitReset;
      cur_pos = '0;
      goal = '0;
      phase = '0;
      dir = szp_pkg::DIR_UP;
      mismatches = 0;
    endfunction

    function void set_reg(szp_pkg::reg_index_t idx, logic [6:0] value);
      case (idx)
        szp_pkg::REG_FIRST_ZONE_POSITION: first_pos = value;
        szp_pkg::REG_ZONE_SPACING:        spacing = value;
        szp_pkg::REG_TRAVEL_LIMIT:        limit = value;
        default: ;
      endcase
    endfunction

    // Work out the move caused by one accepted input transaction.
    function void take_item(szp_pkg::action_t act, logic [7:0] hi, logic [7:0] lo);
      logic [2:0] fields [4];
      logic [2:0] zone;
      int         t;
      int         k;
      move_t      m;
      fields[0] = hi[5:3];
      fields[1] = hi[2:0];
      fields[2] = lo[5:3];
      fields[3] = lo[2:0];
      zone = szp_pkg::ZoneNone;
      for (k = 0; k < 4; k++) begin
        if (zone == szp_pkg::ZoneNone) zone = fields[k];
      end
      m.coils = 4'h0;
      m.stepped = 1'b0;
      if (act == szp_pkg::ACT_MESSAGE) begin
        // Zones one to six set a clamped target; zone seven or no zone leaves it alone.
        if (zone != szp_pkg::ZoneNone && zone != szp_pkg::ZoneIgnore) begin
          t = int'(first_pos) - int'(spacing) * (int'(zone) - 1);
          if (t < 0) t = 0;
          if (t > int'(limit)) t = int'(limit);
          goal = t[6:0];
        end
      end else if (cur_pos != goal) begin
        // One half step toward the target, reporting the pattern of the phase left.
        dir = (goal < cur_pos) ? szp_pkg::DIR_DOWN : szp_pkg::DIR_UP;
        m.coils = coil_seq[phase];
        m.stepped = 1'b1;
        if (dir == szp_pkg::DIR_UP) begin
          cur_pos = cur_pos + 7'd1;
          phase = phase + 3'd1;
        end else begin
          cur_pos = cur_pos - 7'd1;
          phase = phase - 3'd1;
        end
        if (cur_pos == limit) dir = szp_pkg::DIR_DOWN;
        else if (cur_pos == 7'd0) dir = szp_pkg::DIR_UP;
      end
      m.pos = cur_pos;
      m.moving = (cur_pos != goal);
      m.dir = dir;
      pending_moves.push_back(m);
    endfunction

    function void report_mismatch(string what, move_t want, move_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: expected coils=%h stepped=%b pos=%0d moving=%b heading=%b, ",
                 what, want.coils, want.stepped, want.pos, want.moving, want.dir,
                 "got coils=%h stepped=%b pos=%0d moving=%b heading=%b",
                 got.coils, got.stepped, got.pos, got.moving, got.dir);
      end
    endfunction

    // Compare one accepted result transaction with the oldest pending move.
    function void check_move(logic [3:0] coils, logic stp, logic [6:0] pos, logic mov, logic hd);
      move_t got;
      move_t want;
      got.coils = coils;
      got.stepped = stp;
      got.pos = pos;
      got.moving = mov;
      got.dir = szp_pkg::heading_t'(hd);
      if (pending_moves.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_moves.pop_front();
        if (got.coils !== want.coils || got.stepped !== want.stepped || got.pos !== want.pos ||
            got.moving !== want.moving || got.dir !== want.dir) begin
          report_mismatch("mismatch", want, got);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [7:0]  zone_byte_hi;
  logic [7:0]  zone_byte_lo;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  coil_pattern;
  logic        stepped;
  logic [6:0]  position;
  logic        moving;
  logic        heading;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  motion_tracker tracker;
  bit            hold_request;
  int unsigned   cycle_count;

  stepper_zone_positioner dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .zone_byte_hi (zone_byte_hi),
    .zone_byte_lo (zone_byte_lo),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .coil_pattern (coil_pattern),
    .stepped      (stepped),
    .position     (position),
    .moving       (moving),
    .heading      (heading),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog on the whole run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check every result transaction at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tracker.check_move(coil_pattern, stepped, position, moving, heading);
    end
  end

  // Receiver: random stalls, mostly short, plus one long hold-off on request.
  initial begin
    int  dur;
    int  pick;
    int  hold_count;
    bit  hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        for (hold_count = 0; hold_count < LongHold; hold_count++) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          out_ready <= 1'b1;
          dur = $urandom_range(1, 20);
        end else if (pick < 90) begin
          out_ready <= 1'b0;
          dur = $urandom_range(1, 3);
        end else if (pick < 98) begin
          out_ready <= 1'b0;
          dur = $urandom_range(4, 12);
        end else begin
          out_ready <= 1'b0;
          dur = $urandom_range(20, 40);
        end
        repeat (dur) @(posedge clk);
      end
    end
  end

  // Idle time after a transaction: mostly none, a few long gaps.
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one input transaction and hold it until accepted.
  task automatic send_item(szp_pkg::action_t act, logic [7:0] hi, logic [7:0] lo);
    int gap;
    in_valid <= 1'b1;
    action <= act;
    zone_byte_hi <= hi;
    zone_byte_lo <= lo;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_item(act, hi, lo);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Zone message bytes: a random number of leading empty fields, then a zone, then noise.
  function automatic void make_zone_bytes(output logic [7:0] hi, output logic [7:0] lo);
    logic [2:0] f [4];
    int         slot;
    int         k;
    for (k = 0; k < 4; k++) f[k] = 3'($urandom);
    slot = $urandom_range(0, 4);
    for (k = 0; k < slot && k < 4; k++) f[k] = szp_pkg::ZoneNone;
    if (slot < 4) begin
      f[slot] = ($urandom_range(0, 7) == 0) ? szp_pkg::ZoneIgnore
                                             : 3'($urandom_range(1, 6));
    end
    hi = {2'($urandom), f[0], f[1]};
    lo = {2'($urandom), f[2], f[3]};
  endfunction

  // Mostly a message followed by a run of ticks, with some fully random transactions.
  task automatic run_random(int count);
    int         sent;
    int         run;
    logic [7:0] hi;
    logic [7:0] lo;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 8) begin
        make_zone_bytes(hi, lo);
        send_item(szp_pkg::ACT_MESSAGE, hi, lo);
        sent++;
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 140) : $urandom_range(0, 20);
        repeat (run) begin
          send_item(szp_pkg::ACT_TICK, 8'($urandom), 8'($urandom));
          sent++;
        end
      end else begin
        send_item(($urandom_range(0, 1) == 1) ? szp_pkg::ACT_MESSAGE : szp_pkg::ACT_TICK,
                  8'($urandom), 8'($urandom));
        sent++;
      end
    end
  endtask

  // Stop offering and wait until every pending move has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_moves.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup phase, access phase, then idle.
  task automatic write_reg(szp_pkg::reg_index_t idx, logic [6:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {25'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [6:0] first_pos, logic [6:0] spacing, logic [6:0] limit);
    drain();
    write_reg(szp_pkg::REG_FIRST_ZONE_POSITION, first_pos);
    write_reg(szp_pkg::REG_ZONE_SPACING, spacing);
    write_reg(szp_pkg::REG_TRAVEL_LIMIT, limit);
    @(posedge clk);
  endtask

  // Main sequence: reset, directed transactions, then random phases over several settings.
  initial begin
    tracker = new();
    hold_request = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    action <= szp_pkg::ACT_TICK;
    zone_byte_hi <= 8'h00;
    zone_byte_lo <= 8'h00;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Tick with the motor already on target, then messages that must be ignored.
    send_item(szp_pkg::ACT_TICK, 8'h00, 8'h00);
    send_item(szp_pkg::ACT_MESSAGE, 8'hC0, 8'hC0);
    send_item(szp_pkg::ACT_MESSAGE, 8'b00_111_001, 8'h00);
    // Zone one in the first field, then two steps up.
    send_item(szp_pkg::ACT_MESSAGE, 8'b00_001_000, 8'hFF);
    repeat (2) send_item(szp_pkg::ACT_TICK, 8'hFF, 8'hFF);
    // Zone six in the second field; walk to it and past the point of arrival.
    send_item(szp_pkg::ACT_MESSAGE, 8'b00_000_110, 8'h00);
    repeat (5) send_item(szp_pkg::ACT_TICK, 8'h00, 8'hFF);
    // Zone five in the third field and zone two in the last one.
    send_item(szp_pkg::ACT_MESSAGE, 8'hC0, 8'b00_101_000);
    send_item(szp_pkg::ACT_MESSAGE, 8'h00, 8'b11_000_010);
    send_item(szp_pkg::ACT_MESSAGE, 8'h00, 8'b00_000_111);
    repeat (3) send_item(szp_pkg::ACT_TICK, 8'h00, 8'h00);
    // All-ones bytes: the first nonzero field is zone seven.
    send_item(szp_pkg::ACT_MESSAGE, 8'hFF, 8'hFF);
    send_item(szp_pkg::ACT_MESSAGE, 8'h00, 8'hFF);
    // Zone four with a lower-priority zone seven that must not be consulted.
    send_item(szp_pkg::ACT_MESSAGE, 8'b00_100_111, 8'h3F);
    repeat (4) send_item(szp_pkg::ACT_TICK, 8'h55, 8'hAA);

    run_random(PhaseItems);

    // Top of travel reachable; the receiver holds off for a long stretch here.
    apply_setting(7'd127, 7'd0, 7'd127);
    hold_request = 1'b1;
    run_random(PhaseItems);
    // Limit lowered below the current position.
    apply_setting(7'd127, 7'd127, 7'd40);
    run_random(PhaseItems);
    apply_setting(7'd0, 7'd0, 7'd1);
    run_random(PhaseItems);
    apply_setting(7'd0, 7'd127, 7'd127);
    run_random(PhaseItems);
    repeat (2) begin
      apply_setting(7'($urandom), 7'($urandom_range(0, 31)), 7'($urandom_range(1, 127)));
      run_random(PhaseItems);
    end
    apply_setting(szp_pkg::FirstZonePositionReset, szp_pkg::ZoneSpacingReset,
                  szp_pkg::TravelLimitReset);
    run_random(PhaseItems);

    drain();
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_moves.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
